/* rtl/assert_macros.svh */
// assertion helpers, clocked on clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PBM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pbm assertion failed");

// checked at every edge, reset included
`define PBM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pbm assertion failed");

`endif

/* rtl/pbm_pkg.sv */
package pbm_pkg;

  localparam int POS_W    = 13;
  localparam int STATUS_W = 3;

  // classified-byte queue between front and back, power of two deep
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [STATUS_W-1:0] ST_PIXEL   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MAGIC   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_COMMENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIM     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TRUNC   = 3'd5;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic       end_item;
    logic       is_p;
    logic       is_one;
    logic       is_lf;
    logic       is_hash;
    logic       is_plus;
    logic       is_blank;
    logic       is_digit;
    logic [3:0] digit;
  } item_t;

endpackage

/* rtl/pbm_if.sv */
interface pbm_in_if import pbm_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_item;

  modport source (output valid, output byte_in, output end_item, input ready);
  modport sink (input valid, input byte_in, input end_item, output ready);
endinterface

interface pbm_out_if import pbm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                pixel;
  logic [POS_W-1:0]    col;
  logic [POS_W-1:0]    row;
  logic                last_pixel;

  modport source (output valid, output status, output pixel, output col, output row,
                  output last_pixel, input ready);
  modport sink (input valid, input status, input pixel, input col, input row,
                input last_pixel, output ready);
endinterface

/* rtl/pbm_front.sv */
module pbm_front import pbm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  pbm_in_if.sink in_if,
  output logic   q_valid,
  output item_t  q_item,
  input  logic   q_pop
);

  item_t          cls;
  logic [7:0]     byte_sub;
  logic           push;
  item_t          q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;

  // classify the byte
  always_comb begin
    byte_sub     = in_if.byte_in - CH_ZERO;
    cls.end_item = in_if.end_item;
    cls.is_p     = (in_if.byte_in == CH_P);
    cls.is_one   = (in_if.byte_in == CH_ONE);
    cls.is_lf    = (in_if.byte_in == CH_LF);
    cls.is_hash  = (in_if.byte_in == CH_HASH);
    cls.is_plus  = (in_if.byte_in == CH_PLUS);
    cls.is_blank = (in_if.byte_in == CH_SPACE) ||
                   ((in_if.byte_in >= CH_TAB) && (in_if.byte_in <= CH_CR));
    cls.is_digit = (in_if.byte_in >= CH_ZERO) && (in_if.byte_in <= CH_NINE);
    cls.digit    = byte_sub[3:0];
  end

  assign in_if.ready = (count_r != (QAW+1)'(QDEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign q_valid     = (count_r != '0);
  assign q_item      = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/pbm_back.sv */
module pbm_back import pbm_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  pbm_out_if.source  out_if
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int ACC_W = DIM_W + 4;

  typedef enum logic [3:0] {
    PH_P, PH_ONE, PH_LF, PH_HASH, PH_COMMENT, PH_WLEAD, PH_WBODY,
    PH_HLEAD, PH_HBODY, PH_PIXELS, PH_HALT
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [DIM_W-1:0]    acc_r, acc_nxt;
  logic                seen_r, seen_nxt;
  logic                big_r, big_nxt;
  logic [DIM_W-1:0]    width_r, width_nxt;
  logic [DIM_W-1:0]    height_r, height_nxt;
  logic [DIM_W-1:0]    col_r, col_nxt;
  logic [DIM_W-1:0]    row_r, row_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic                pixel_r;
  logic [POS_W-1:0]    col_out_r;
  logic [POS_W-1:0]    row_out_r;
  logic                last_r;

  logic                take;
  logic                base_zero;
  logic [ACC_W-1:0]    base;
  logic [ACC_W-1:0]    sum;
  logic                sum_big;
  logic [DIM_W-1:0]    acc_add;
  logic [DIM_W-1:0]    pos_x;
  logic [DIM_W-1:0]    pos_y;
  logic                is_pix;

  logic                res_valid;
  logic [STATUS_W-1:0] res_status;
  logic                res_pixel;
  logic [DIM_W-1:0]    res_x;
  logic [DIM_W-1:0]    res_y;
  logic                res_last;

  assign take  = !out_valid_r || out_if.ready;
  assign q_pop = q_valid && take;

  // acc * 10 + digit, a fresh number starts from zero
  assign base_zero = (phase_r == PH_WLEAD) || (phase_r == PH_HLEAD);
  assign base      = base_zero ? '0 : ACC_W'(acc_r);
  assign sum       = (base << 3) + (base << 1) + ACC_W'(q_item.digit);
  assign sum_big   = (sum > ACC_W'(MAX_DIM));
  assign acc_add   = sum_big ? DIM_W'(MAX_DIM) : sum[DIM_W-1:0];

  assign pos_x  = col_r + 1'b1;
  assign pos_y  = row_r + 1'b1;
  assign is_pix = q_item.is_digit && (q_item.digit[3:1] == 3'b000);

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    seen_nxt   = seen_r;
    big_nxt    = big_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    res_valid  = 1'b0;
    res_status = ST_PIXEL;
    res_pixel  = 1'b0;
    res_x      = '0;
    res_y      = '0;
    res_last   = 1'b0;

    if (q_pop) begin
      if (q_item.end_item) begin
        res_valid = 1'b1;
        case (phase_r)
          PH_P, PH_ONE, PH_LF: res_status = ST_MAGIC;
          PH_HASH:             res_status = ST_COMMENT;
          PH_HBODY: begin
            if (!seen_r || big_r) begin
              res_status = ST_DIM;
            end else if ((width_r == '0) || (acc_r == '0)) begin
              res_status = ST_EMPTY;
            end else begin
              res_status = ST_TRUNC;
            end
          end
          PH_PIXELS:           res_status = ST_TRUNC;
          PH_HALT:             res_valid  = 1'b0;
          default:             res_status = ST_DIM;
        endcase
        phase_nxt  = PH_P;
        acc_nxt    = '0;
        seen_nxt   = 1'b0;
        big_nxt    = 1'b0;
        width_nxt  = '0;
        height_nxt = '0;
        col_nxt    = '0;
        row_nxt    = '0;
      end else begin
        case (phase_r)
          PH_P: begin
            if (q_item.is_p) begin
              phase_nxt = PH_ONE;
            end else begin
              phase_nxt  = PH_HALT;
              res_valid  = 1'b1;
              res_status = ST_MAGIC;
            end
          end
          PH_ONE: begin
            if (q_item.is_one) begin
              phase_nxt = PH_LF;
            end else begin
              phase_nxt  = PH_HALT;
              res_valid  = 1'b1;
              res_status = ST_MAGIC;
            end
          end
          PH_LF: begin
            if (q_item.is_lf) begin
              phase_nxt = PH_HASH;
            end else begin
              phase_nxt  = PH_HALT;
              res_valid  = 1'b1;
              res_status = ST_MAGIC;
            end
          end
          PH_HASH: begin
            if (q_item.is_hash) begin
              phase_nxt = PH_COMMENT;
            end else begin
              phase_nxt  = PH_HALT;
              res_valid  = 1'b1;
              res_status = ST_COMMENT;
            end
          end
          PH_COMMENT: begin
            if (q_item.is_lf) begin
              phase_nxt = PH_WLEAD;
            end
          end
          PH_WLEAD, PH_HLEAD: begin
            if (!q_item.is_blank) begin
              acc_nxt   = '0;
              seen_nxt  = 1'b0;
              big_nxt   = 1'b0;
              phase_nxt = (phase_r == PH_WLEAD) ? PH_WBODY : PH_HBODY;
              if (q_item.is_digit) begin
                acc_nxt  = acc_add;
                seen_nxt = 1'b1;
                big_nxt  = sum_big;
              end else if (!q_item.is_plus) begin
                phase_nxt  = PH_HALT;
                res_valid  = 1'b1;
                res_status = ST_DIM;
              end
            end
          end
          PH_WBODY: begin
            if (q_item.is_digit) begin
              acc_nxt  = acc_add;
              seen_nxt = 1'b1;
              big_nxt  = big_r || sum_big;
            end else if (!seen_r || big_r) begin
              phase_nxt  = PH_HALT;
              res_valid  = 1'b1;
              res_status = ST_DIM;
            end else begin
              // terminating byte doubles as the first lead byte of the height
              width_nxt = acc_r;
              if (q_item.is_blank) begin
                phase_nxt = PH_HLEAD;
              end else if (q_item.is_plus) begin
                acc_nxt   = '0;
                seen_nxt  = 1'b0;
                big_nxt   = 1'b0;
                phase_nxt = PH_HBODY;
              end else begin
                phase_nxt  = PH_HALT;
                res_valid  = 1'b1;
                res_status = ST_DIM;
              end
            end
          end
          PH_HBODY: begin
            if (q_item.is_digit) begin
              acc_nxt  = acc_add;
              seen_nxt = 1'b1;
              big_nxt  = big_r || sum_big;
            end else if (!seen_r || big_r) begin
              phase_nxt  = PH_HALT;
              res_valid  = 1'b1;
              res_status = ST_DIM;
            end else begin
              height_nxt = acc_r;
              col_nxt    = '0;
              row_nxt    = '0;
              if ((width_r == '0) || (acc_r == '0)) begin
                phase_nxt  = PH_HALT;
                res_valid  = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                phase_nxt = PH_PIXELS;
              end
            end
          end
          PH_PIXELS: begin
            if (is_pix) begin
              res_valid  = 1'b1;
              res_status = ST_PIXEL;
              res_pixel  = q_item.digit[0];
              res_x      = pos_x;
              res_y      = pos_y;
              if (pos_x >= width_r) begin
                col_nxt = '0;
                row_nxt = pos_y;
                if (pos_y >= height_r) begin
                  res_last  = 1'b1;
                  phase_nxt = PH_HALT;
                end
              end else begin
                col_nxt = pos_x;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_P;
      acc_r       <= '0;
      seen_r      <= 1'b0;
      big_r       <= 1'b0;
      width_r     <= '0;
      height_r    <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      seen_r   <= seen_nxt;
      big_r    <= big_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      if (take) begin
        out_valid_r <= res_valid;
        if (res_valid) begin
          status_r  <= res_status;
          pixel_r   <= res_pixel;
          col_out_r <= POS_W'(res_x);
          row_out_r <= POS_W'(res_y);
          last_r    <= res_last;
        end
      end
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = status_r;
  assign out_if.pixel      = pixel_r;
  assign out_if.col        = col_out_r;
  assign out_if.row        = row_out_r;
  assign out_if.last_pixel = last_r;

endmodule

/* rtl/pbm_ascii_bitmap_parser_unit.sv */
// ASCII P1 bitmap parser.
// in_if carries one file byte per beat (byte_in), or an end-of-file marker
// (end_item high, byte ignored). out_if carries at most one result per input
// beat: a pixel with its 1-based column and row and a last-pixel flag, or a
// status code for an empty image or a header/stream error.
// Throughput is one byte per cycle while the receiver does not stall. A front
// stage classifies each byte into a two-entry queue; the back stage runs the
// header/pixel state machine and writes a registered output, so a result
// passes through a queue entry and then the output register.
// If the receiver stalls, the output register holds its beat, the queue fills
// and in_if.ready drops once both entries are full; no byte is lost.
// After an error or the last pixel, bytes are swallowed silently until the
// end marker, which restarts the parser for the next file.
// Synchronous reset empties the queue, drops out_if.valid and returns the
// parser to waiting for the first magic byte; no clearing pass is needed.
// MAX_DIM bounds width and height; larger values give a dimension error.
module pbm_ascii_bitmap_parser_unit import pbm_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  pbm_in_if.sink    in_if,
  pbm_out_if.source out_if
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  pbm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  pbm_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

/* rtl/pbm_checker.sv */
`include "assert_macros.svh"

module pbm_checker import pbm_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_pixel,
  input logic [POS_W-1:0]    out_col,
  input logic [POS_W-1:0]    out_row,
  input logic                out_last_pixel
);

  `PBM_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid)

  `PBM_ASSERT(a_stall_holds_valid, out_valid && !out_ready |=> out_valid)

  `PBM_ASSERT(a_stall_holds_beat, out_valid && !out_ready |=> $stable(out_status) && $stable(out_pixel) && $stable(out_col) && $stable(out_row) && $stable(out_last_pixel))

  // status beats carry no position
  `PBM_ASSERT(a_status_no_pos, out_valid && (out_status != ST_PIXEL) |-> (out_col == '0) && (out_row == '0) && !out_pixel && !out_last_pixel)

  `PBM_ASSERT(a_last_is_pixel, out_valid && out_last_pixel |-> out_status == ST_PIXEL)

endmodule

bind pbm_ascii_bitmap_parser_unit pbm_checker u_pbm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_status     (out_if.status),
  .out_pixel      (out_if.pixel),
  .out_col        (out_if.col),
  .out_row        (out_if.row),
  .out_last_pixel (out_if.last_pixel)
);
